FILE: src/b32d_pkg.sv
// Shared types and constants for the base32 text decoder.
package b32d_pkg;

  localparam int SymbolWidth = 8;
  localparam int DigitWidth  = 5;
  localparam int CountWidth  = 12;
  localparam int StoreWidth  = 12;
  localparam int HeldWidth   = 3;

  // result codes carried on the kind port
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // character codes
  localparam logic [SymbolWidth-1:0] CHAR_NUL   = 8'h00;
  localparam logic [SymbolWidth-1:0] CHAR_TAB   = 8'h09;
  localparam logic [SymbolWidth-1:0] CHAR_LF    = 8'h0A;
  localparam logic [SymbolWidth-1:0] CHAR_CR    = 8'h0D;
  localparam logic [SymbolWidth-1:0] CHAR_SPACE = 8'h20;
  localparam logic [SymbolWidth-1:0] CHAR_DASH  = 8'h2D;
  localparam logic [SymbolWidth-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [SymbolWidth-1:0] CHAR_ONE   = 8'h31;
  localparam logic [SymbolWidth-1:0] CHAR_TWO   = 8'h32;
  localparam logic [SymbolWidth-1:0] CHAR_SEVEN = 8'h37;
  localparam logic [SymbolWidth-1:0] CHAR_EIGHT = 8'h38;
  localparam logic [SymbolWidth-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [SymbolWidth-1:0] CHAR_UP_B  = 8'h42;
  localparam logic [SymbolWidth-1:0] CHAR_UP_L  = 8'h4C;
  localparam logic [SymbolWidth-1:0] CHAR_UP_O  = 8'h4F;
  localparam logic [SymbolWidth-1:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [SymbolWidth-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [SymbolWidth-1:0] CHAR_LO_Z  = 8'h7A;
  // '2' - 26: offset that maps the digits 2..7 onto 26..31
  localparam logic [SymbolWidth-1:0] DIGIT_BASE = 8'd24;

  localparam logic [CountWidth-1:0] LIMIT_RESET = 12'd64;

  // classification of one character
  typedef struct packed {
    logic                  is_end;
    logic                  is_skip;
    logic                  is_digit;
    logic [DigitWidth-1:0] digit;
  } char_class_t;

  // one result item
  typedef struct packed {
    logic                   valid;
    kind_t                  kind;
    logic [7:0]             data;
    logic [CountWidth-1:0]  total;
  } result_t;

endpackage

FILE: src/b32d_char_map.sv
// Character classifier: maps one text character to a base32 digit value.
module b32d_char_map (
  input  logic [b32d_pkg::SymbolWidth-1:0] symbol,
  output b32d_pkg::char_class_t            cls
);

  logic [b32d_pkg::SymbolWidth-1:0] c;
  logic [b32d_pkg::SymbolWidth-1:0] num;
  logic                             is_letter;
  logic                             is_num;

  // mistyped digits read as look-alike letters
  always_comb begin
    priority if (symbol == b32d_pkg::CHAR_ZERO) begin
      c = b32d_pkg::CHAR_UP_O;
    end else if (symbol == b32d_pkg::CHAR_ONE) begin
      c = b32d_pkg::CHAR_UP_L;
    end else if (symbol == b32d_pkg::CHAR_EIGHT) begin
      c = b32d_pkg::CHAR_UP_B;
    end else begin
      c = symbol;
    end
  end

  assign is_letter = (c >= b32d_pkg::CHAR_UP_A && c <= b32d_pkg::CHAR_UP_Z)
                  || (c >= b32d_pkg::CHAR_LO_A && c <= b32d_pkg::CHAR_LO_Z);
  assign is_num    = (c >= b32d_pkg::CHAR_TWO && c <= b32d_pkg::CHAR_SEVEN);
  assign num       = c - b32d_pkg::DIGIT_BASE;

  always_comb begin
    cls.is_end   = (symbol == b32d_pkg::CHAR_NUL);
    cls.is_skip  = (symbol == b32d_pkg::CHAR_SPACE) || (symbol == b32d_pkg::CHAR_TAB)
                || (symbol == b32d_pkg::CHAR_CR)    || (symbol == b32d_pkg::CHAR_LF)
                || (symbol == b32d_pkg::CHAR_DASH);
    cls.is_digit = is_letter || is_num;
    if (is_letter) begin
      cls.digit = c[b32d_pkg::DigitWidth-1:0] - 5'd1;
    end else begin
      cls.digit = num[b32d_pkg::DigitWidth-1:0];
    end
  end

endmodule

FILE: src/b32d_core.sv
// Decoder state and per-character update: bit store, byte count, discard flag.
module b32d_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  b32d_pkg::char_class_t           cls,
  input  logic [b32d_pkg::CountWidth-1:0] output_limit,
  output b32d_pkg::result_t               res
);

  logic [b32d_pkg::StoreWidth-1:0] bit_store;
  logic [b32d_pkg::StoreWidth-1:0] bit_store_next;
  logic [b32d_pkg::HeldWidth-1:0]  bits_held;
  logic [b32d_pkg::HeldWidth-1:0]  bits_held_next;
  logic [b32d_pkg::CountWidth-1:0] bytes_out;
  logic [b32d_pkg::CountWidth-1:0] bytes_out_next;
  logic                            discarding;
  logic                            discarding_next;

  logic [b32d_pkg::StoreWidth-1:0] shifted;
  logic [b32d_pkg::HeldWidth:0]    held_plus;
  logic [b32d_pkg::HeldWidth:0]    held_left;
  logic [b32d_pkg::CountWidth-1:0] bytes_inc;
  logic [7:0]                      out_byte;

  assign shifted   = {bit_store[b32d_pkg::StoreWidth-b32d_pkg::DigitWidth-1:0], cls.digit};
  assign held_plus = {1'b0, bits_held} + 4'd5;
  assign held_left = held_plus - 4'd8;
  assign bytes_inc = bytes_out + 12'd1;
  assign out_byte  = 8'(shifted >> held_left[2:0]);

  always_comb begin
    bit_store_next  = bit_store;
    bits_held_next  = bits_held;
    bytes_out_next  = bytes_out;
    discarding_next = discarding;
    res.valid       = 1'b0;
    res.kind        = b32d_pkg::KIND_BYTE;
    res.data        = 8'd0;
    res.total       = bytes_out;
    if (step) begin
      priority if (cls.is_end) begin
        res.valid       = 1'b1;
        res.kind        = b32d_pkg::KIND_DONE;
        bit_store_next  = '0;
        bits_held_next  = '0;
        bytes_out_next  = '0;
        discarding_next = 1'b0;
      end else if (discarding || bytes_out >= output_limit || cls.is_skip) begin
        // ignored
      end else if (!cls.is_digit) begin
        res.valid       = 1'b1;
        res.kind        = b32d_pkg::KIND_ERROR;
        discarding_next = 1'b1;
      end else begin
        bit_store_next = shifted;
        if (held_plus[3]) begin
          bits_held_next = held_left[2:0];
          bytes_out_next = bytes_inc;
          res.valid      = 1'b1;
          res.data       = out_byte;
          res.total      = bytes_inc;
        end else begin
          bits_held_next = held_plus[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store  <= '0;
      bits_held  <= '0;
      bytes_out  <= '0;
      discarding <= 1'b0;
    end else begin
      bit_store  <= bit_store_next;
      bits_held  <= bits_held_next;
      bytes_out  <= bytes_out_next;
      discarding <= discarding_next;
    end
  end

`ifndef SYNTH
  a_held_below_byte: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == b32d_pkg::KIND_BYTE |=> bits_held <= 3'd4)
    else $error("too many bits left after a byte");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && cls.is_end |=> bytes_out == '0 && bits_held == '0 && !discarding)
    else $error("terminator did not clear the string state");

  a_byte_counts: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == b32d_pkg::KIND_BYTE |=> bytes_out == $past(bytes_out) + 12'd1)
    else $error("byte result without count increment");

  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    step && discarding && !cls.is_end |-> !res.valid)
    else $error("result while discarding");
`endif

endmodule

FILE: src/base32_text_decoder.sv
// Top level of the base32 text decoder: input register, decode core, result register.
// Base32 text decoder. One character enters per transaction on symbol; a zero
// character ends the string. Each result transaction carries kind (decoded byte,
// string done, or invalid character), data_byte and byte_total. The block
// sustains one character per clock while the output is not stalled: a character
// is held in the input register, is decoded and applied to the bit store in the
// cycle it advances, and any result is captured in the output register at the
// same edge as the bit store update. The input side stalls only while the output
// register holds a result that is itself stalled. The user must write output_limit
// through config_write/config_data only while no string character is in flight;
// the block itself does not enforce this. Reset value is 64.
module base32_text_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            config_write,
  input  logic [b32d_pkg::CountWidth-1:0] config_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [b32d_pkg::SymbolWidth-1:0] symbol,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      kind,
  output logic [7:0]                      data_byte,
  output logic [b32d_pkg::CountWidth-1:0] byte_total
);

  logic [b32d_pkg::CountWidth-1:0]  output_limit;
  logic                             in_full;
  logic [b32d_pkg::SymbolWidth-1:0] in_sym;
  logic                             go;
  b32d_pkg::char_class_t            cls;
  b32d_pkg::result_t                res;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= b32d_pkg::LIMIT_RESET;
    end else if (config_write) begin
      output_limit <= config_data;
    end
  end

  // the held character advances whenever the result slot is free or draining
  assign go       = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_sym <= symbol;
    end
  end

  b32d_char_map u_map (
    .symbol (in_sym),
    .cls    (cls)
  );

  b32d_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (go),
    .cls          (cls),
    .output_limit (output_limit),
    .res          (res)
  );

  // result register; a new result overwrites one leaving this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res.valid) begin
      kind       <= res.kind;
      data_byte  <= res.data;
      byte_total <= res.total;
    end
  end

endmodule
